/* src/rgbacc_pkg.sv */
package rgbacc_pkg;

    localparam int SAMPLES_PER_GROUP_DEF = 5;
    localparam int WORD_W                = 16;
    localparam int NUM_COLORS            = 9;

    localparam logic [3:0] COLOR_RED    = 4'd0;
    localparam logic [3:0] COLOR_GREEN  = 4'd1;
    localparam logic [3:0] COLOR_BLUE   = 4'd2;
    localparam logic [3:0] COLOR_BLACK  = 4'd3;
    localparam logic [3:0] COLOR_WHITE  = 4'd4;
    localparam logic [3:0] COLOR_ORANGE = 4'd5;
    localparam logic [3:0] COLOR_YELLOW = 4'd6;
    localparam logic [3:0] COLOR_PURPLE = 4'd7;
    localparam logic [3:0] COLOR_BROWN  = 4'd8;
    localparam logic [3:0] COLOR_ABSENT = 4'd9;

    localparam logic [1:0] DIR_RIGHT  = 2'd0;
    localparam logic [1:0] DIR_LEFT   = 2'd1;
    localparam logic [1:0] DIR_CENTER = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] raw_red;
        logic [WORD_W-1:0] raw_green;
        logic [WORD_W-1:0] raw_blue;
    } t_rgb_in;

    typedef struct packed {
        logic [3:0]        color_code;
        logic [1:0]        direction;
        logic [WORD_W-1:0] mean_red;
        logic [WORD_W-1:0] mean_green;
        logic [WORD_W-1:0] mean_blue;
    } t_rgb_out;

    function automatic logic between(logic [WORD_W-1:0] v, logic [WORD_W-1:0] lo,
                                     logic [WORD_W-1:0] hi);
        return (v > lo) && (v < hi);
    endfunction

    function automatic logic [3:0] classify(logic [WORD_W-1:0] r, logic [WORD_W-1:0] g,
                                            logic [WORD_W-1:0] b);
        logic [3:0] c;
        if (r >= 16'd50000 && between(g, 16'd21000, 16'd26000)
                && between(b, 16'd21000, 16'd26000)) begin
            c = COLOR_RED;
        end else if (between(r, 16'd9000, 16'd13000) && between(g, 16'd31000, 16'd36500)
                && between(b, 16'd30000, 16'd35000)) begin
            c = COLOR_GREEN;
        end else if (between(r, 16'd10500, 16'd15000) && between(g, 16'd46000, 16'd52500)
                && b > 16'd63000) begin
            c = COLOR_BLUE;
        end else if ((between(r, 16'd7000, 16'd11000) && between(g, 16'd12000, 16'd16500)
                && between(b, 16'd17500, 16'd22000))
                || (between(r, 16'd5500, 16'd8500) && between(g, 16'd9000, 16'd12000)
                && between(b, 16'd11000, 16'd15000))) begin
            c = COLOR_BLACK;
        end else if ((r > 16'd62000 && g > 16'd64500 && b > 16'd64500)
                || (between(r, 16'd25000, 16'd33000) && between(g, 16'd33000, 16'd44000)
                && b > 16'd50000)) begin
            c = COLOR_WHITE;
        end else if (r > 16'd57000 && between(g, 16'd22500, 16'd27500)
                && between(b, 16'd16000, 16'd23500)) begin
            c = COLOR_ORANGE;
        end else if (r > 16'd63000 && g > 16'd64000 && between(b, 16'd33000, 16'd39000)) begin
            c = COLOR_YELLOW;
        end else if (r > 16'd48000 && between(g, 16'd21000, 16'd27500)
                && between(b, 16'd31000, 16'd37500)) begin
            c = COLOR_PURPLE;
        end else if (between(r, 16'd12000, 16'd17000) && between(g, 16'd14000, 16'd18500)
                && between(b, 16'd17000, 16'd23500)) begin
            c = COLOR_BROWN;
        end else begin
            c = COLOR_ABSENT;
        end
        return c;
    endfunction

endpackage

/* src/rgb_average_color_classifier_core.sv */
// Path: the last request of a group is totaled into r_tot when it is accepted, and its
// classified result is then registered into r_out, raising o_out_valid, once the output is not stalled.
// Throughput: one request per cycle while o_in_stall is low; one result per SAMPLES_PER_GROUP requests.
// The input stalls only on the last request of a group while a stalled result holds
// both the total register and the result register.
// Reset: synchronous, active low; clears sample count, sums, side mask and all valids.
module rgb_average_color_classifier_core #(
    parameter int SAMPLES_PER_GROUP = rgbacc_pkg::SAMPLES_PER_GROUP_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  rgbacc_pkg::t_rgb_in                  i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output rgbacc_pkg::t_rgb_out                 o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [rgbacc_pkg::NUM_COLORS-1:0]    i_cfg_wdata
);

    localparam int W     = rgbacc_pkg::WORD_W;
    localparam int SUM_W = W + $clog2(SAMPLES_PER_GROUP);
    localparam int CNT_W = (SAMPLES_PER_GROUP > 1) ? $clog2(SAMPLES_PER_GROUP) : 1;
    localparam int K     = SUM_W + $clog2(SAMPLES_PER_GROUP);
    localparam int P_W   = SUM_W + K + 1;
    localparam longint unsigned RECIP_L =
        ((64'd1 << K) + SAMPLES_PER_GROUP - 1) / SAMPLES_PER_GROUP;
    localparam logic [K:0]       RECIP    = (K+1)'(RECIP_L);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_GROUP - 1);

    logic [rgbacc_pkg::NUM_COLORS-1:0] r_mask;
    logic [CNT_W-1:0]                  r_cnt;
    logic [SUM_W-1:0]                  r_sum  [3];
    logic                              r_tot_vld;
    logic [SUM_W-1:0]                  r_tot  [3];
    logic                              r_out_vld;
    rgbacc_pkg::t_rgb_out              r_out;

    logic [W-1:0]     swapped [3];
    logic [SUM_W-1:0] n_sum   [3];
    logic [W-1:0]     n_mean  [3];
    logic [P_W-1:0]   prod    [3];
    logic             out_ready;
    logic             tot_ready;
    logic             last;
    logic             take_in;
    logic [3:0]       n_color;
    logic [1:0]       n_dir;

    assign out_ready  = !r_out_vld || !i_out_stall;
    assign tot_ready  = !r_tot_vld || out_ready;
    assign last       = (r_cnt == LAST_CNT);
    assign o_in_stall = last && !tot_ready;
    assign take_in    = i_in_valid && !o_in_stall;

    assign swapped[0] = {i_in_data.raw_red[7:0],   i_in_data.raw_red[15:8]};
    assign swapped[1] = {i_in_data.raw_green[7:0], i_in_data.raw_green[15:8]};
    assign swapped[2] = {i_in_data.raw_blue[7:0],  i_in_data.raw_blue[15:8]};

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_sum[c]  = r_sum[c] + SUM_W'(swapped[c]);
            prod[c]   = P_W'(r_tot[c]) * P_W'(RECIP);
            n_mean[c] = prod[c][K +: W];
        end
    end

    always_comb begin
        n_color = rgbacc_pkg::classify(n_mean[0], n_mean[1], n_mean[2]);
        if (n_color == rgbacc_pkg::COLOR_ABSENT) begin
            n_dir = rgbacc_pkg::DIR_CENTER;
        end else if (r_mask[n_color]) begin
            n_dir = rgbacc_pkg::DIR_LEFT;
        end else begin
            n_dir = rgbacc_pkg::DIR_RIGHT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask     <= '0;
            r_cnt      <= '0;
            r_sum      <= '{default: '0};
            r_tot_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            // accumulate; close the group on its last sample
            if (take_in) begin
                if (last) begin
                    r_cnt <= '0;
                    r_sum <= '{default: '0};
                    r_tot <= n_sum;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    r_sum <= n_sum;
                end
            end
            if (tot_ready) begin
                r_tot_vld <= take_in && last;
            end
            if (out_ready) begin
                r_out_vld        <= r_tot_vld;
                r_out.color_code <= n_color;
                r_out.direction  <= n_dir;
                r_out.mean_red   <= n_mean[0];
                r_out.mean_green <= n_mean[1];
                r_out.mean_blue  <= n_mean[2];
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

/* src/rgbacc_checker.sv */
module rgbacc_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input rgbacc_pkg::t_rgb_out o_out_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    a_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.color_code == rgbacc_pkg::COLOR_ABSENT)
                         == (o_out_data.direction == rgbacc_pkg::DIR_CENTER)))
        else $error("center side does not match absent color");

    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.color_code <= rgbacc_pkg::COLOR_ABSENT
                        && o_out_data.direction <= rgbacc_pkg::DIR_CENTER)
        else $error("result code out of range");

endmodule

bind rgb_average_color_classifier_core rgbacc_checker u_rgbacc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
